### sv/odp_pkg.sv
// ----------------------------------------------------------------------------
// odp_pkg
// Types, constants and helpers shared by the ray optical depth block.
// ----------------------------------------------------------------------------
package odp_pkg;

	localparam int MESH_X_DEF = 64;
	localparam int MESH_Y_DEF = 64;
	localparam int MESH_Z_DEF = 64;

	localparam int ADDR_W = 18;
	localparam int STORE_DEPTH = 1 << ADDR_W;
	localparam int DENS_W = 32;
	localparam int FRAC_W = 17;
	localparam int COORD_W = 32;
	localparam int SIZE_W = 31;
	localparam int DEPTH_W = 48;
	localparam int CFG_IDX_W = 3;
	localparam int QUEUE_DEPTH = 2;
	localparam int DIV_CNT_W = 7;

	localparam logic [FRAC_W-1:0] FRAC_ONE = 17'h10000;
	localparam logic [63:0] T_ONE = 64'h0000_0001_0000_0000;
	localparam logic [63:0] T_CAP = 64'h8000_0000_0000_0000;
	localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;
	localparam logic [SIZE_W-1:0] CELL_SIZE_RESET = 31'd65536;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_TRACE = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ORIGIN_X = 3'd0,
		REG_ORIGIN_Y = 3'd1,
		REG_ORIGIN_Z = 3'd2,
		REG_CELL_SIZE_X = 3'd3,
		REG_CELL_SIZE_Y = 3'd4,
		REG_CELL_SIZE_Z = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic [2:0][COORD_W-1:0] origin;
		logic [2:0][SIZE_W-1:0] cell_size;
	} cfg_t;

	typedef struct packed {
		logic is_trace;
		logic [ADDR_W-1:0] cell_index;
		logic [DENS_W-1:0] density;
		logic [FRAC_W-1:0] fraction;
		logic [2:0][COORD_W-1:0] start_pos;
		logic [2:0][COORD_W-1:0] end_pos;
	} item_t;

	typedef struct packed {
		logic start;
		logic [31:0] rem;
		logic [63:0] num;
		logic [31:0] den;
		logic [DIV_CNT_W-1:0] cnt;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic [63:0] quo;
	} div_rsp_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_SU_PREP,
		ST_SU_IDXS,
		ST_SU_IDXE,
		ST_SQRT,
		ST_DIV,
		ST_CHECK,
		ST_ADDR1,
		ST_ADDR2,
		ST_READ,
		ST_NHI,
		ST_BND,
		ST_TPREP,
		ST_TSTORE,
		ST_STEP,
		ST_MUL,
		ST_MULEND,
		ST_OUT
	} back_state_t;

	function automatic logic [31:0] eff_size(logic [SIZE_W-1:0] c);
		return (c == '0) ? 32'd1 : {1'b0, c};
	endfunction

endpackage

### sv/odp_if.sv
// ----------------------------------------------------------------------------
// odp_if
// Valid/ready channels for trace and load items and for optical depth results.
// ----------------------------------------------------------------------------
interface odp_in_if;
	logic valid;
	logic ready;
	logic command;
	logic [17:0] cell_index;
	logic [31:0] cell_density;
	logic [16:0] neutral_fraction;
	logic [31:0] start_x;
	logic [31:0] start_y;
	logic [31:0] start_z;
	logic [31:0] end_x;
	logic [31:0] end_y;
	logic [31:0] end_z;

	modport source (output valid, command, cell_index, cell_density, neutral_fraction,
		start_x, start_y, start_z, end_x, end_y, end_z, input ready);
	modport sink (input valid, command, cell_index, cell_density, neutral_fraction,
		start_x, start_y, start_z, end_x, end_y, end_z, output ready);
endinterface

interface odp_out_if;
	logic valid;
	logic ready;
	logic [47:0] optical_depth;
	logic saturated;

	modport source (output valid, optical_depth, saturated, input ready);
	modport sink (input valid, optical_depth, saturated, output ready);
endinterface

### sv/ray_voxel_optical_depth.sv
// ----------------------------------------------------------------------------
// ray_voxel_optical_depth
// Voxel walk of a ray segment through a density mesh, summing optical depth.
// ----------------------------------------------------------------------------
// A load item is written to the mesh store when it leaves the queue while no
// trace is being worked. A trace's setup runs six 32-step divisions and a 33-step
// square root; each cell crossed then runs up to three 63-step divisions in the
// shared divider, and the end cell closes the walk.
// One trace is worked at a time while a two-item queue accepts input until full.
// Reset restores the configuration and control registers; the mesh store is not cleared.
module ray_voxel_optical_depth import odp_pkg::*; #(
	parameter int MESH_X = MESH_X_DEF,
	parameter int MESH_Y = MESH_Y_DEF,
	parameter int MESH_Z = MESH_Z_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_wr_en,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [31:0] cfg_data,
	odp_in_if.sink items,
	odp_out_if.source results
);

	cfg_t cfg_q;
	logic q_valid;
	logic q_ready;
	item_t q_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.origin <= '0;
			cfg_q.cell_size <= {CELL_SIZE_RESET, CELL_SIZE_RESET, CELL_SIZE_RESET};
		end else if (cfg_wr_en) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_ORIGIN_X: cfg_q.origin[0] <= cfg_data;
				REG_ORIGIN_Y: cfg_q.origin[1] <= cfg_data;
				REG_ORIGIN_Z: cfg_q.origin[2] <= cfg_data;
				REG_CELL_SIZE_X: cfg_q.cell_size[0] <= cfg_data[SIZE_W-1:0];
				REG_CELL_SIZE_Y: cfg_q.cell_size[1] <= cfg_data[SIZE_W-1:0];
				REG_CELL_SIZE_Z: cfg_q.cell_size[2] <= cfg_data[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	odp_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.items(items),
		.q_valid(q_valid),
		.q_ready(q_ready),
		.q_item(q_item)
	);

	odp_back #(
		.MESH_X(MESH_X),
		.MESH_Y(MESH_Y),
		.MESH_Z(MESH_Z)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.q_valid(q_valid),
		.q_ready(q_ready),
		.q_item(q_item),
		.results(results)
	);

	a_sat_flag: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid |-> (results.saturated == (results.optical_depth == DEPTH_MAX)))
		else $error("Saturation flag disagrees with the optical depth.");

	a_no_pop_while_result: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid |-> !q_ready)
		else $error("Queue was popped while a result was pending.");

	a_cell_size_write: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_wr_en && cfg_index == REG_CELL_SIZE_X) |=>
		(cfg_q.cell_size[0] == $past(cfg_data[SIZE_W-1:0])))
		else $error("Cell size x write was lost.");

endmodule

### sv/odp_front.sv
// ----------------------------------------------------------------------------
// odp_front
// Accepts items, tags them as load or trace, and holds them in a short queue.
// ----------------------------------------------------------------------------
module odp_front import odp_pkg::*; (
	input logic clk,
	input logic arst_n,
	odp_in_if.sink items,
	output logic q_valid,
	input logic q_ready,
	output item_t q_item
);

	localparam int QP_W = $clog2(QUEUE_DEPTH);

	item_t fifo_q [QUEUE_DEPTH];
	logic [QP_W-1:0] wr_ptr_q;
	logic [QP_W-1:0] rd_ptr_q;
	logic [QP_W:0] count_q;
	item_t in_item;
	logic push;
	logic pop;

	always_comb begin
		in_item.is_trace = (items.command == CMD_TRACE);
		in_item.cell_index = items.cell_index;
		in_item.density = items.cell_density;
		in_item.fraction = items.neutral_fraction;
		in_item.start_pos = {items.start_z, items.start_y, items.start_x};
		in_item.end_pos = {items.end_z, items.end_y, items.end_x};
	end

	assign items.ready = (count_q != (QP_W+1)'(QUEUE_DEPTH));
	assign push = items.valid && items.ready;
	assign q_valid = (count_q != '0);
	assign pop = q_valid && q_ready;
	assign q_item = fifo_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) fifo_q[wr_ptr_q] <= in_item;
	end

endmodule

### sv/odp_div.sv
// ----------------------------------------------------------------------------
// odp_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module odp_div import odp_pkg::*; (
	input logic clk,
	input logic arst_n,
	input div_req_t req,
	output div_rsp_t rsp
);

	logic busy_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [31:0] rem_q;
	logic [63:0] num_q;
	logic [63:0] quo_q;
	logic [31:0] den_q;
	logic [32:0] r2;
	logic ge;
	logic [31:0] rem_n;

	always_comb begin
		r2 = {rem_q, num_q[63]};
		ge = (r2 >= {1'b0, den_q});
		rem_n = ge ? 32'(r2 - {1'b0, den_q}) : r2[31:0];
	end

	assign rsp.done = busy_q && (cnt_q == '0);
	assign rsp.quo = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q <= req.cnt;
		end else if (busy_q) begin
			if (cnt_q == '0) busy_q <= 1'b0;
			else cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.rem;
			num_q <= req.num;
			den_q <= req.den;
			quo_q <= '0;
		end else if (busy_q && (cnt_q != '0)) begin
			rem_q <= rem_n;
			num_q <= {num_q[62:0], 1'b0};
			quo_q <= {quo_q[62:0], ge};
		end
	end

endmodule

### sv/odp_back.sv
// ----------------------------------------------------------------------------
// odp_back
// Mesh store and ray walk sequencer: setup, cell stepping and accumulation.
// ----------------------------------------------------------------------------
module odp_back import odp_pkg::*; #(
	parameter int MESH_X = MESH_X_DEF,
	parameter int MESH_Y = MESH_Y_DEF,
	parameter int MESH_Z = MESH_Z_DEF
) (
	input logic clk,
	input logic arst_n,
	input cfg_t cfg,
	input logic q_valid,
	output logic q_ready,
	input item_t q_item,
	odp_out_if.source results
);

	localparam int MESH_MAX = (MESH_X > MESH_Y) ?
		((MESH_X > MESH_Z) ? MESH_X : MESH_Z) : ((MESH_Y > MESH_Z) ? MESH_Y : MESH_Z);
	localparam int CUR_W = $clog2(MESH_MAX + 1) + 1;
	localparam int B_W = 32 + CUR_W;
	localparam int N_W = B_W + 1;

	typedef logic signed [CUR_W-1:0] cur_t;

	localparam cur_t MESH_LAST [3] = '{cur_t'(MESH_X - 1), cur_t'(MESH_Y - 1),
		cur_t'(MESH_Z - 1)};

	back_state_t state_q, state_n, ret_q;
	logic [1:0] ax_q;
	logic [5:0] cnt_q;
	logic tail_q;
	logic res_valid_q;
	logic [1:0] mul_k_q;
	logic mul_ph_q;

	item_t item_q;
	logic signed [32:0] sl_q [3];
	logic signed [32:0] d_q [3];
	logic [31:0] mag_q [3];
	cur_t cur_q [3];
	cur_t endc_q [3];
	logic [63:0] ta_q [3];
	logic [2:0] tv_q;
	logic signed [32:0] el_q;
	logic [65:0] sum_q;
	logic [35:0] srem_q;
	logic [32:0] root_q;
	logic [63:0] t_q;
	logic [63:0] dt_q;
	logic [DEPTH_W-1:0] acc_q;
	logic [31:0] nhi_q;
	logic signed [N_W-1:0] n_q;
	logic [ADDR_W-1:0] row_q;
	logic [ADDR_W-1:0] addr_q;
	logic [63:0] mul_a_q;
	logic [47:0] mul_b_q;
	logic [96:0] mul_p_q;
	logic [DENS_W+FRAC_W-1:0] mem_q [STORE_DEPTH];
	logic [DENS_W+FRAC_W-1:0] rd_q;

	div_req_t div_req;
	div_rsp_t div_rsp;
	logic mem_we;

	logic [31:0] s_c, e_c, o_c, cs_c;
	logic signed [32:0] sl_c, el_c, d_c;
	logic [31:0] mag_c, sl_abs_c, el_abs_c;
	logic [63:0] sq_c;
	logic walk_on;
	logic pos_c;
	cur_t cpos_c;
	logic [B_W-1:0] b_c;
	logic signed [N_W-1:0] n_c;
	logic n_pos, t_cap, launch;
	logic [63:0] tmin_c, nt_c, tail_dt_c;
	logic have_c;
	cur_t sx, sy, sz;
	logic [FRAC_W-1:0] frac_c;
	logic [DENS_W+FRAC_W-1:0] nprod_c;
	logic [15:0] chunk_c;
	logic [79:0] part_c;
	logic [63:0] len_c;
	logic [DEPTH_W-1:0] inc_c;
	logic [DEPTH_W:0] accsum_c;

	function automatic cur_t clamp_idx(logic neg, logic [31:0] q, cur_t last);
		if (neg) return '0;
		if (q > 32'(last)) return last;
		return cur_t'(q);
	endfunction

	odp_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.req(div_req),
		.rsp(div_rsp)
	);

	always_comb begin
		s_c = item_q.start_pos[ax_q];
		e_c = item_q.end_pos[ax_q];
		o_c = cfg.origin[ax_q];
		cs_c = eff_size(cfg.cell_size[ax_q]);
		sl_c = $signed({s_c[31], s_c}) - $signed({o_c[31], o_c});
		el_c = $signed({e_c[31], e_c}) - $signed({o_c[31], o_c});
		d_c = $signed({e_c[31], e_c}) - $signed({s_c[31], s_c});
		mag_c = d_c[32] ? 32'(-d_c) : d_c[31:0];
		sl_abs_c = sl_c[32] ? 32'(-sl_c) : sl_c[31:0];
		el_abs_c = el_q[32] ? 32'(-el_q) : el_q[31:0];
		sq_c = {32'b0, mag_c} * {32'b0, mag_c};

		walk_on = 1'b0;
		for (int a = 0; a < 3; a++) begin
			if (cur_q[a] != endc_q[a]) walk_on = 1'b1;
		end
		for (int a = 0; a < 3; a++) begin
			if (cur_q[a] < 0 || cur_q[a] > MESH_LAST[a]) walk_on = 1'b0;
		end

		pos_c = !d_q[ax_q][32];
		cpos_c = cur_q[ax_q] + (pos_c ? cur_t'(1) : cur_t'(0));
		b_c = B_W'(cs_c) * B_W'($unsigned(cpos_c));
		n_c = pos_c ? ($signed({1'b0, b_c}) - N_W'(sl_q[ax_q]))
			: (N_W'(sl_q[ax_q]) - $signed({1'b0, b_c}));
		n_pos = (n_q > 0);
		t_cap = (64'(n_q) >= {1'b0, mag_q[ax_q], 31'b0});
		launch = n_pos && !t_cap;

		have_c = 1'b0;
		tmin_c = '1;
		for (int a = 0; a < 3; a++) begin
			if (tv_q[a]) begin
				have_c = 1'b1;
				if (ta_q[a] < tmin_c) tmin_c = ta_q[a];
			end
		end
		nt_c = (tmin_c > t_q) ? tmin_c : t_q;
		tail_dt_c = (t_q >= T_ONE) ? (t_q - T_ONE) : (T_ONE - t_q);

		sx = tail_q ? endc_q[0] : cur_q[0];
		sy = tail_q ? endc_q[1] : cur_q[1];
		sz = tail_q ? endc_q[2] : cur_q[2];

		frac_c = (rd_q[FRAC_W-1:0] > FRAC_ONE) ? FRAC_ONE : rd_q[FRAC_W-1:0];
		nprod_c = (DENS_W+FRAC_W)'(rd_q[DENS_W+FRAC_W-1:FRAC_W]) * (DENS_W+FRAC_W)'(frac_c);

		chunk_c = mul_b_q[{mul_k_q, 4'b0} +: 16];
		part_c = mul_a_q * chunk_c;
		len_c = (|mul_p_q[96:80]) ? '1 : mul_p_q[79:16];
		inc_c = (|mul_p_q[96:72]) ? DEPTH_MAX : mul_p_q[71:24];
		accsum_c = {1'b0, acc_q} + {1'b0, inc_c};
	end

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE: if (q_valid && q_item.is_trace) state_n = ST_SU_PREP;
			ST_SU_PREP: state_n = ST_DIV;
			ST_DIV: if (div_rsp.done) state_n = ret_q;
			ST_SU_IDXS: state_n = ST_DIV;
			ST_SU_IDXE: state_n = (ax_q == 2'd2) ? ST_SQRT : ST_SU_PREP;
			ST_SQRT: if (cnt_q == 6'd1) state_n = ST_CHECK;
			ST_CHECK: state_n = ST_ADDR1;
			ST_ADDR1: state_n = ST_ADDR2;
			ST_ADDR2: state_n = ST_READ;
			ST_READ: state_n = ST_NHI;
			ST_NHI: state_n = tail_q ? ST_MUL : ST_BND;
			ST_BND: begin
				if (d_q[ax_q] != '0) state_n = ST_TPREP;
				else if (ax_q == 2'd2) state_n = ST_STEP;
			end
			ST_TPREP: begin
				if (launch) state_n = ST_DIV;
				else state_n = (ax_q == 2'd2) ? ST_STEP : ST_BND;
			end
			ST_TSTORE: state_n = (ax_q == 2'd2) ? ST_STEP : ST_BND;
			ST_STEP: state_n = have_c ? ST_MUL : ST_ADDR1;
			ST_MUL: if (mul_k_q == 2'd2) state_n = ST_MULEND;
			ST_MULEND: begin
				if (!mul_ph_q) state_n = ST_MUL;
				else state_n = tail_q ? ST_OUT : ST_CHECK;
			end
			ST_OUT: if (results.ready) state_n = ST_IDLE;
			default: state_n = ST_IDLE;
		endcase
	end

	always_comb begin
		q_ready = (state_q == ST_IDLE);
		mem_we = 1'b0;
		div_req = '0;
		unique case (state_q)
			ST_IDLE: mem_we = q_valid && !q_item.is_trace;
			ST_SU_PREP: begin
				div_req.start = 1'b1;
				div_req.num = {sl_abs_c, 32'b0};
				div_req.den = cs_c;
				div_req.cnt = DIV_CNT_W'(32);
			end
			ST_SU_IDXS: begin
				div_req.start = 1'b1;
				div_req.num = {el_abs_c, 32'b0};
				div_req.den = cs_c;
				div_req.cnt = DIV_CNT_W'(32);
			end
			ST_TPREP: begin
				div_req.start = launch;
				div_req.rem = 32'($unsigned(n_q[N_W-1:31]));
				div_req.num = {n_q[30:0], 33'b0};
				div_req.den = mag_q[ax_q];
				div_req.cnt = DIV_CNT_W'(63);
			end
			default: ;
		endcase
	end

	assign results.valid = res_valid_q;
	assign results.optical_depth = acc_q;
	assign results.saturated = (acc_q == DEPTH_MAX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ret_q <= ST_IDLE;
			ax_q <= '0;
			cnt_q <= '0;
			tail_q <= 1'b0;
			res_valid_q <= 1'b0;
			mul_k_q <= '0;
			mul_ph_q <= 1'b0;
		end else begin
			state_q <= state_n;
			case (state_q)
				ST_IDLE: begin
					ax_q <= '0;
					tail_q <= 1'b0;
				end
				ST_SU_PREP: ret_q <= ST_SU_IDXS;
				ST_SU_IDXS: ret_q <= ST_SU_IDXE;
				ST_SU_IDXE: begin
					if (ax_q == 2'd2) cnt_q <= 6'd33;
					else ax_q <= ax_q + 1'b1;
				end
				ST_SQRT: cnt_q <= cnt_q - 1'b1;
				ST_CHECK: if (!walk_on) tail_q <= 1'b1;
				ST_NHI: begin
					ax_q <= '0;
					mul_k_q <= '0;
					mul_ph_q <= 1'b0;
				end
				ST_BND: if (d_q[ax_q] == '0 && ax_q != 2'd2) ax_q <= ax_q + 1'b1;
				ST_TPREP: begin
					ret_q <= ST_TSTORE;
					if (!launch && ax_q != 2'd2) ax_q <= ax_q + 1'b1;
				end
				ST_TSTORE: if (ax_q != 2'd2) ax_q <= ax_q + 1'b1;
				ST_STEP: begin
					if (!have_c) tail_q <= 1'b1;
					mul_k_q <= '0;
					mul_ph_q <= 1'b0;
				end
				ST_MUL: mul_k_q <= mul_k_q + 1'b1;
				ST_MULEND: begin
					mul_k_q <= '0;
					mul_ph_q <= 1'b1;
					if (mul_ph_q && tail_q) res_valid_q <= 1'b1;
				end
				ST_OUT: if (results.ready) res_valid_q <= 1'b0;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				item_q <= q_item;
				sum_q <= '0;
				srem_q <= '0;
				root_q <= '0;
				t_q <= '0;
				acc_q <= '0;
				tv_q <= '0;
			end
			ST_SU_PREP: begin
				sl_q[ax_q] <= sl_c;
				d_q[ax_q] <= d_c;
				mag_q[ax_q] <= mag_c;
				el_q <= el_c;
				sum_q <= sum_q + {2'b0, sq_c};
			end
			ST_SU_IDXS: cur_q[ax_q] <= clamp_idx(sl_q[ax_q][32], div_rsp.quo[31:0],
				MESH_LAST[ax_q]);
			ST_SU_IDXE: endc_q[ax_q] <= clamp_idx(el_q[32], div_rsp.quo[31:0],
				MESH_LAST[ax_q]);
			ST_SQRT: begin
				sum_q <= {sum_q[63:0], 2'b00};
				if ({srem_q[33:0], sum_q[65:64]} >= {1'b0, root_q, 2'b01}) begin
					srem_q <= {srem_q[33:0], sum_q[65:64]} - {1'b0, root_q, 2'b01};
					root_q <= {root_q[31:0], 1'b1};
				end else begin
					srem_q <= {srem_q[33:0], sum_q[65:64]};
					root_q <= {root_q[31:0], 1'b0};
				end
			end
			ST_CHECK: if (!walk_on) dt_q <= tail_dt_c;
			ST_ADDR1: row_q <= ADDR_W'($unsigned(sy)) + ADDR_W'(MESH_Y) * ADDR_W'($unsigned(sx));
			ST_ADDR2: addr_q <= ADDR_W'($unsigned(sz)) + ADDR_W'(MESH_Z) * row_q;
			ST_NHI: begin
				nhi_q <= nprod_c[47:16];
				mul_a_q <= dt_q;
				mul_b_q <= {15'b0, root_q};
				mul_p_q <= '0;
			end
			ST_BND: begin
				n_q <= n_c;
				if (d_q[ax_q] == '0) tv_q[ax_q] <= 1'b0;
			end
			ST_TPREP: begin
				if (!launch) begin
					ta_q[ax_q] <= n_pos ? T_CAP : '0;
					tv_q[ax_q] <= 1'b1;
				end
			end
			ST_TSTORE: begin
				ta_q[ax_q] <= {1'b0, div_rsp.quo[62:0]};
				tv_q[ax_q] <= 1'b1;
			end
			ST_STEP: begin
				if (have_c) begin
					for (int a = 0; a < 3; a++) begin
						if (tv_q[a] && ta_q[a] == tmin_c) begin
							cur_q[a] <= d_q[a][32] ? (cur_q[a] - cur_t'(1))
								: (cur_q[a] + cur_t'(1));
						end
					end
					dt_q <= nt_c - t_q;
					mul_a_q <= nt_c - t_q;
					t_q <= nt_c;
				end else begin
					dt_q <= tail_dt_c;
				end
				mul_b_q <= {15'b0, root_q};
				mul_p_q <= '0;
			end
			ST_MUL: mul_p_q <= mul_p_q + (97'(part_c) << {mul_k_q, 4'b0});
			ST_MULEND: begin
				if (!mul_ph_q) begin
					mul_a_q <= len_c;
					mul_b_q <= {16'b0, nhi_q};
					mul_p_q <= '0;
				end else begin
					acc_q <= accsum_c[DEPTH_W] ? DEPTH_MAX : accsum_c[DEPTH_W-1:0];
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem_q[q_item.cell_index] <= {q_item.density, q_item.fraction};
		rd_q <= mem_q[addr_q];
	end

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for ray_voxel_optical_depth. Load items fill the mesh,
// trace items walk rays through it; a predictor in the bench computes the
// expected optical depth of each trace and a checker compares every result.
// Rays are built so that every cell they read has been loaded first.
// ----------------------------------------------------------------------------
module tb import odp_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [DEPTH_W-1:0] depth;
		logic sat;
	} depth_rec_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	odp_in_if in_ch();
	odp_out_if out_ch();

	ray_voxel_optical_depth uut (
		.clk(clk), .arst_n(arst_n), .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .items(in_ch), .results(out_ch)
	);

	always #5 clk = ~clk;

	logic [31:0] reg_origin [3];
	logic [30:0] reg_size [3];
	bit [31:0] dens_mem [int];
	bit [16:0] frac_mem [int];
	depth_rec_t depth_q [$];
	int errors = 0;
	int idle_pct = 0;
	int stall_pct = 0;

	function automatic longint sx(logic [31:0] v);
		return longint'(signed'(v));
	endfunction

	function automatic longint size_of(int a);
		return (reg_size[a] == '0) ? 64'd1 : longint'({33'b0, reg_size[a]});
	endfunction

	function automatic int cell_addr(longint x, longint y, longint z);
		longint v;
		v = z + MESH_Z_DEF * (y + MESH_Y_DEF * x);
		return int'(v & 64'h3FFFF);
	endfunction

	function automatic bit [63:0] absorber(int addr);
		bit [63:0] f, dn;
		f = frac_mem.exists(addr) ? frac_mem[addr] : 0;
		dn = dens_mem.exists(addr) ? dens_mem[addr] : 0;
		if (f > 64'd65536) f = 64'd65536;
		return (dn * f) >> 16;
	endfunction

	function automatic bit [63:0] mul_shift(bit [63:0] a, bit [63:0] b, int sh,
			bit [63:0] cap);
		bit [127:0] p;
		p = ({64'b0, a} * {64'b0, b}) >> sh;
		return (p > {64'b0, cap}) ? cap : p[63:0];
	endfunction

	function automatic bit [63:0] root_floor(bit [127:0] v);
		bit [63:0] r, c;
		r = 0;
		for (int b = 33; b >= 0; b--) begin
			c = r | (64'd1 << b);
			if ({64'b0, c} * {64'b0, c} <= v) r = c;
		end
		return r;
	endfunction

	function automatic bit [63:0] crossing_t(bit [63:0] n, bit [63:0] d);
		bit [63:0] q, r;
		q = n / d;
		r = n % d;
		if (q >= 64'h8000_0000) return T_CAP;
		return (q << 32) + ((r << 32) / d);
	endfunction

	function automatic bit [63:0] add_depth(bit [63:0] acc, bit [63:0] dt,
			bit [63:0] len_q, bit [63:0] nhi);
		bit [63:0] len, s;
		len = mul_shift(dt, len_q, 16, '1);
		s = acc + mul_shift(len, nhi, 24, {16'b0, DEPTH_MAX});
		return (s > {16'b0, DEPTH_MAX}) ? {16'b0, DEPTH_MAX} : s;
	endfunction

	// Walks the ray; lists every cell read and returns the accumulated depth.
	function automatic void walk_ray(input item_t it, ref int cells [$],
			output bit [63:0] depth);
		longint sl [3], d [3], cur [3], endc [3], csz [3], nm [3];
		longint s, e, b, n;
		bit [63:0] ta [3];
		bit vld [3];
		bit [63:0] mag, tmin, t, nt, len_q, acc, nhi;
		bit [127:0] sq;
		bit have;
		sq = 0;
		t = 0;
		acc = 0;
		nm = '{MESH_X_DEF, MESH_Y_DEF, MESH_Z_DEF};
		for (int a = 0; a < 3; a++) begin
			csz[a] = size_of(a);
			s = sx(it.start_pos[a]);
			e = sx(it.end_pos[a]);
			sl[a] = s - sx(reg_origin[a]);
			cur[a] = sl[a] / csz[a];
			endc[a] = (e - sx(reg_origin[a])) / csz[a];
			if (cur[a] > nm[a] - 1) cur[a] = nm[a] - 1;
			if (cur[a] < 0) cur[a] = 0;
			if (endc[a] > nm[a] - 1) endc[a] = nm[a] - 1;
			if (endc[a] < 0) endc[a] = 0;
			d[a] = e - s;
			mag = (d[a] < 0) ? -d[a] : d[a];
			sq += {64'b0, mag} * {64'b0, mag};
		end
		len_q = root_floor(sq);
		while ((cur[0] != endc[0] || cur[1] != endc[1] || cur[2] != endc[2]) &&
				cur[0] >= 0 && cur[0] < nm[0] && cur[1] >= 0 && cur[1] < nm[1] &&
				cur[2] >= 0 && cur[2] < nm[2]) begin
			cells.push_back(cell_addr(cur[0], cur[1], cur[2]));
			nhi = absorber(cell_addr(cur[0], cur[1], cur[2]));
			tmin = '1;
			have = 0;
			for (int a = 0; a < 3; a++) begin
				vld[a] = 0;
				if (d[a] != 0) begin
					b = csz[a] * (cur[a] + ((d[a] > 0) ? 1 : 0));
					n = (d[a] > 0) ? b - sl[a] : sl[a] - b;
					ta[a] = (n <= 0) ? 0 : crossing_t(n, (d[a] < 0) ? -d[a] : d[a]);
					vld[a] = 1;
					have = 1;
					if (ta[a] < tmin) tmin = ta[a];
				end
			end
			if (!have) break;
			for (int a = 0; a < 3; a++)
				if (vld[a] && ta[a] == tmin) cur[a] += (d[a] > 0) ? 1 : -1;
			nt = (tmin > t) ? tmin : t;
			acc = add_depth(acc, nt - t, len_q, nhi);
			t = nt;
		end
		cells.push_back(cell_addr(endc[0], endc[1], endc[2]));
		depth = add_depth(acc, (t >= T_ONE) ? t - T_ONE : T_ONE - t, len_q,
			absorber(cell_addr(endc[0], endc[1], endc[2])));
	endfunction

	function automatic item_t rand_item();
		item_t it;
		it.is_trace = 1'($urandom_range(0, 1));
		it.cell_index = 18'($urandom);
		it.density = $urandom;
		it.fraction = 17'($urandom);
		for (int a = 0; a < 3; a++) begin
			it.start_pos[a] = $urandom;
			it.end_pos[a] = $urandom;
		end
		return it;
	endfunction

	function automatic bit [31:0] rand_density();
		return ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 1 << 20);
	endfunction

	function automatic bit [16:0] rand_fraction();
		return ($urandom_range(0, 7) == 0) ? 17'($urandom_range(65537, 131071))
			: 17'($urandom_range(0, 65536));
	endfunction

	function automatic item_t make_ray(int span);
		item_t it;
		longint ci, ce, csz;
		it = rand_item();
		it.is_trace = CMD_TRACE;
		for (int a = 0; a < 3; a++) begin
			csz = size_of(a);
			ci = $urandom_range(0, 63);
			ce = ci + longint'($urandom_range(0, 2 * span)) - span;
			it.start_pos[a] = 32'(sx(reg_origin[a]) + ci * csz
				+ longint'($urandom_range(0, 32'(csz - 1))));
			it.end_pos[a] = 32'(sx(reg_origin[a]) + ce * csz
				+ longint'($urandom_range(0, 32'(csz - 1))));
		end
		return it;
	endfunction

	task automatic send_item(item_t it);
		while ($urandom_range(0, 99) < idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.command <= it.is_trace;
		in_ch.cell_index <= it.cell_index;
		in_ch.cell_density <= it.density;
		in_ch.neutral_fraction <= it.fraction;
		in_ch.start_x <= it.start_pos[0];
		in_ch.start_y <= it.start_pos[1];
		in_ch.start_z <= it.start_pos[2];
		in_ch.end_x <= it.end_pos[0];
		in_ch.end_y <= it.end_pos[1];
		in_ch.end_z <= it.end_pos[2];
		do @(posedge clk); while (!in_ch.ready);
	endtask

	task automatic wait_idle();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (depth_q.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic load_cell(int addr, bit [31:0] dn, bit [16:0] fr);
		item_t it;
		it = rand_item();
		it.is_trace = CMD_LOAD;
		it.cell_index = 18'(addr);
		it.density = dn;
		it.fraction = fr;
		dens_mem[addr] = dn;
		frac_mem[addr] = fr;
		send_item(it);
	endtask

	task automatic trace_ray(item_t it);
		int cells [$];
		bit [63:0] depth;
		depth_rec_t rec;
		it.is_trace = CMD_TRACE;
		walk_ray(it, cells, depth);
		foreach (cells[i])
			if (!dens_mem.exists(cells[i]))
				load_cell(cells[i], rand_density(), rand_fraction());
		cells.delete();
		walk_ray(it, cells, depth);
		rec.depth = depth[DEPTH_W-1:0];
		rec.sat = (depth[DEPTH_W-1:0] == DEPTH_MAX);
		depth_q.push_back(rec);
		send_item(it);
	endtask

	task automatic set_config(longint ox, longint oy, longint oz,
			bit [31:0] cx, bit [31:0] cy, bit [31:0] cz);
		cfg_reg_t regs [6];
		bit [31:0] vals [6];
		regs = '{REG_ORIGIN_X, REG_ORIGIN_Y, REG_ORIGIN_Z,
			REG_CELL_SIZE_X, REG_CELL_SIZE_Y, REG_CELL_SIZE_Z};
		vals = '{ox[31:0], oy[31:0], oz[31:0], cx, cy, cz};
		wait_idle();
		foreach (regs[i]) begin
			cfg_wr_en <= 1'b1;
			cfg_index <= regs[i];
			cfg_data <= vals[i];
			@(posedge clk);
		end
		cfg_wr_en <= 1'b0;
		for (int a = 0; a < 3; a++) begin
			reg_origin[a] = vals[a];
			reg_size[a] = vals[a + 3][30:0];
		end
	endtask

	function automatic item_t ray_at(longint sx0, longint sy0, longint sz0,
			longint ex0, longint ey0, longint ez0);
		item_t it;
		it = rand_item();
		it.is_trace = CMD_TRACE;
		it.start_pos[0] = 32'(sx0);
		it.start_pos[1] = 32'(sy0);
		it.start_pos[2] = 32'(sz0);
		it.end_pos[0] = 32'(ex0);
		it.end_pos[1] = 32'(ey0);
		it.end_pos[2] = 32'(ez0);
		return it;
	endfunction

	task automatic test_directed();
		longint h, lo, hi;
		h = 32768;
		lo = -64'sd2147483648;
		hi = 64'sd2147483647;
		trace_ray(ray_at(5 * 65536 + h, 5 * 65536 + h, 5 * 65536 + h,
			5 * 65536 + h, 5 * 65536 + h, 5 * 65536 + h));
		trace_ray(ray_at(h, h, h, 10 * 65536 + h, h, h));
		trace_ray(ray_at(10 * 65536 + h, 3 * 65536 + h, 3 * 65536 + h,
			65536 + h, 3 * 65536 + h, 3 * 65536 + h));
		trace_ray(ray_at(h, h, h, 4 * 65536 + h, 4 * 65536 + h, 4 * 65536 + h));
		trace_ray(ray_at(-5 * 65536, 2 * 65536 + h, 2 * 65536 + h,
			3 * 65536 + h, 2 * 65536 + h, 2 * 65536 + h));
		trace_ray(ray_at(3 * 65536 + h, 3 * 65536 + h, 3 * 65536 + h,
			100 * 65536, 3 * 65536 + h, 3 * 65536 + h));
		trace_ray(ray_at(lo, lo, lo, hi, hi, hi));
		trace_ray(ray_at(hi, hi, hi, lo, lo, lo));
		trace_ray(ray_at(lo, hi, 0, lo, hi, 65536));
		trace_ray(ray_at(20 * 65536, 20 * 65536, 20 * 65536,
			20 * 65536, 25 * 65536 + 1, 19 * 65536 - 1));
		load_cell(cell_addr(30, 30, 30), 0, 17'h10000);
		load_cell(cell_addr(31, 30, 30), 32'hFFFF_FFFF, 0);
		trace_ray(ray_at(30 * 65536 + h, 30 * 65536 + h, 30 * 65536 + h,
			31 * 65536 + h, 30 * 65536 + h, 30 * 65536 + h));
		wait_idle();
		for (int x = 0; x < 64; x++) load_cell(cell_addr(x, 7, 7), '1, 17'h1FFFF);
		trace_ray(ray_at(h, 7 * 65536 + h, 7 * 65536 + h,
			63 * 65536 + h, 7 * 65536 + h, 7 * 65536 + h));
	endtask

	task automatic run_random(int count, int pause_at);
		item_t it;
		int r;
		for (int i = 0; i < count; i++) begin
			if (i == pause_at) wait_idle();
			r = $urandom_range(0, 99);
			if (r < 40) begin
				trace_ray(make_ray(($urandom_range(0, 19) == 0) ? 8 : 2));
			end else if (r < 46) begin
				it = rand_item();
				for (int a = 0; a < 3; a++)
					it.end_pos[a] = it.start_pos[a] ^ $urandom_range(0, 1 << 20);
				trace_ray(it);
			end else if (r < 50) begin
				it = make_ray(2);
				it.end_pos = it.start_pos;
				trace_ray(it);
			end else begin
				it = rand_item();
				if (dens_mem.exists(int'(it.cell_index)) && depth_q.size() != 0)
					wait_idle();
				load_cell(int'(it.cell_index), ($urandom_range(0, 1)) ? it.density
					: rand_density(), it.fraction);
			end
		end
	endtask

	task automatic test_random();
		int idle_set [4] = '{0, 79, 0, 22};
		int stall_set [4] = '{0, 0, 79, 22};
		for (int ph = 0; ph < 4; ph++) begin
			set_config(longint'($urandom_range(0, 1 << 29)) - (1 << 28),
				longint'($urandom_range(0, 1 << 29)) - (1 << 28),
				longint'($urandom_range(0, 1 << 29)) - (1 << 28),
				{1'($urandom_range(0, 1)), 31'($urandom_range(1, 1 << 22))},
				{1'($urandom_range(0, 1)), 31'($urandom_range(1, 1 << 22))},
				{1'($urandom_range(0, 1)), 31'($urandom_range(1, 1 << 22))});
			idle_pct = idle_set[ph];
			stall_pct = stall_set[ph];
			run_random(70, (ph == 1) ? 35 : -1);
		end
	endtask

	task automatic test_extremes();
		idle_pct = 22;
		stall_pct = 22;
		set_config(-64'sd2147483648, 64'sd2147483647, 0, 0, 32'hFFFF_FFFF, 1);
		for (int i = 0; i < 8; i++) trace_ray(make_ray(2));
		set_config(64'sd2147483647, -64'sd2147483648, 64'sd2147483647,
			32'h7FFF_FFFF, 1, 0);
		for (int i = 0; i < 8; i++) trace_ray(make_ray(2));
		set_config(0, 0, 0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
	endtask

	always @(posedge clk) out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);

	always @(posedge clk) begin : check_results
		depth_rec_t e;
		if (out_ch.valid && out_ch.ready) begin
			if (depth_q.size() == 0) begin
				$error("result with no trace pending: optical_depth %0h",
					out_ch.optical_depth);
				errors++;
			end else begin
				e = depth_q.pop_front();
				if (out_ch.optical_depth !== e.depth) begin
					$error("optical_depth expected %0h actual %0h", e.depth,
						out_ch.optical_depth);
					errors++;
				end
				if (out_ch.saturated !== e.sat) begin
					$error("saturated expected %0b actual %0b", e.sat, out_ch.saturated);
					errors++;
				end
			end
		end
	end

	initial begin
		in_ch.valid = 1'b0;
		in_ch.command = CMD_LOAD;
		in_ch.cell_index = '0;
		in_ch.cell_density = '0;
		in_ch.neutral_fraction = '0;
		in_ch.start_x = '0;
		in_ch.start_y = '0;
		in_ch.start_z = '0;
		in_ch.end_x = '0;
		in_ch.end_y = '0;
		in_ch.end_z = '0;
		for (int a = 0; a < 3; a++) begin
			reg_origin[a] = '0;
			reg_size[a] = CELL_SIZE_RESET;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random();
		test_extremes();
		wait_idle();
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("** ray_voxel_optical_depth: PASSED **");
		else
			$display("** ray_voxel_optical_depth: FAILED **");
		$finish;
	end

	initial begin
		#1000ms;
		$display("** ray_voxel_optical_depth: FAILED **");
		$finish;
	end
endmodule
